>>> design/vpt_pkg.sv
`default_nettype none
package vpt_pkg;

  typedef struct packed {
    logic signed [15:0] vertex_x;
    logic signed [15:0] vertex_y;
    logic signed [15:0] vertex_z;
  } vpt_in_t;

  typedef struct packed {
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic signed [15:0] depth;
    logic               divide_overflow;
  } vpt_out_t;

  // register indexes
  localparam logic [2:0] REG_ROW_X    = 3'd0;
  localparam logic [2:0] REG_ROW_Y    = 3'd1;
  localparam logic [2:0] REG_ROW_Z    = 3'd2;
  localparam logic [2:0] REG_OFFSET_X = 3'd3;
  localparam logic [2:0] REG_OFFSET_Y = 3'd4;
  localparam logic [2:0] REG_OFFSET_Z = 3'd5;
  localparam logic [2:0] REG_CENTRE_X = 3'd6;
  localparam logic [2:0] REG_CENTRE_Y = 3'd7;

  localparam int CENTRE_RESET = 128;

  // divider: quotient magnitude bits resolved, bits per pipeline stage
  localparam int DIV_QBITS          = 20;
  localparam int DIV_BITS_PER_STAGE = 4;
  localparam int DIV_STAGES         = DIV_QBITS / DIV_BITS_PER_STAGE;

  // transform stages, divider stages (prep + iterations)
  localparam int XFORM_STAGES = 2;
  localparam int PIPE_DEPTH   = XFORM_STAGES + DIV_STAGES + 1;

  typedef struct packed {
    logic [31:0]          rem;
    logic [DIV_QBITS-1:0] q;
    logic [15:0]          dmag;
    logic                 neg;
    logic                 nneg;
    logic                 zero;
    logic                 big;
  } div_st_t;

endpackage
`default_nettype wire

>>> design/vpt_transform.sv
`default_nettype none
module vpt_transform
  import vpt_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               en,
  input  wire vpt_in_t            vtx,
  input  wire logic [47:0]        row_x,
  input  wire logic [47:0]        row_y,
  input  wire logic [47:0]        row_z,
  input  wire logic signed [15:0] offset_x,
  input  wire logic signed [15:0] offset_y,
  input  wire logic signed [15:0] offset_z,
  output logic signed [31:0]      view_x,
  output logic signed [31:0]      view_y,
  output logic signed [15:0]      depth
);

  logic [47:0] rows [3];
  logic signed [31:0] pp_nxt [3];
  logic signed [31:0] pc_nxt [3];
  logic signed [31:0] pab_nxt [3];
  logic signed [31:0] pp_r [3];
  logic signed [31:0] pc_r [3];
  logic signed [31:0] pab_r [3];
  logic signed [31:0] pxy_r;
  logic signed [31:0] sum [3];
  logic signed [31:0] view_x_r, view_y_r;
  logic signed [15:0] depth_r;
  logic signed [31:0] dz_full;

  assign rows[0] = row_x;
  assign rows[1] = row_y;
  assign rows[2] = row_z;

  // stage 1: paired products per row
  always_comb begin
    logic signed [15:0] a, b, c, t0, t1;
    for (int r = 0; r < 3; r++) begin
      a = $signed(rows[r][15:0]);
      b = $signed(rows[r][31:16]);
      c = $signed(rows[r][47:32]);
      t0 = a + vtx.vertex_y;
      t1 = b + vtx.vertex_x;
      pp_nxt[r]  = t0 * t1;
      pc_nxt[r]  = c * vtx.vertex_z;
      pab_nxt[r] = a * b;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_r  <= pp_nxt;
      pc_r  <= pc_nxt;
      pab_r <= pab_nxt;
      pxy_r <= 32'(vtx.vertex_x * vtx.vertex_y);
    end
  end

  // stage 2: row sums, correction, translation
  always_comb begin
    for (int r = 0; r < 3; r++)
      sum[r] = pp_r[r] + pc_r[r] - pxy_r;
    dz_full = (sum[2] >>> 12) + 32'(offset_z) - (pab_r[2] >>> 12);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      view_x_r <= (sum[0] >>> 4) + $signed({{8{offset_x[15]}}, offset_x, 8'd0})
                  - (pab_r[0] >>> 4);
      view_y_r <= (sum[1] >>> 4) + $signed({{8{offset_y[15]}}, offset_y, 8'd0})
                  - (pab_r[1] >>> 4);
      depth_r  <= dz_full[15:0];
    end
  end

  assign view_x = view_x_r;
  assign view_y = view_y_r;
  assign depth  = depth_r;

endmodule
`default_nettype wire

>>> design/vpt_divider.sv
`default_nettype none
module vpt_divider
  import vpt_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [31:0] num,
  input  wire logic signed [15:0] den,
  output logic signed [15:0]      quot,
  output logic                    ovf
);

  div_st_t st_r [DIV_STAGES+1];
  div_st_t st_nxt [DIV_STAGES+1];

  // prep: magnitudes, signs, range check against D * 2^DIV_QBITS
  // then restoring steps, DIV_BITS_PER_STAGE quotient bits per stage
  always_comb begin
    logic [31:0] nmag;
    logic [15:0] dmag;
    div_st_t cur;
    logic [35:0] sh;
    int k;
    nmag = num[31] ? 32'(-num) : 32'(num);
    dmag = den[15] ? 16'(-den) : 16'(den);
    st_nxt[0].rem  = nmag;
    st_nxt[0].q    = '0;
    st_nxt[0].dmag = dmag;
    st_nxt[0].neg  = num[31] ^ den[15];
    st_nxt[0].nneg = num[31];
    st_nxt[0].zero = (den == 16'sd0);
    st_nxt[0].big  = ({4'd0, nmag} >= {dmag, 20'd0});
    for (int s = 0; s < DIV_STAGES; s++) begin
      cur = st_r[s];
      for (int j = 0; j < DIV_BITS_PER_STAGE; j++) begin
        k = DIV_QBITS - 1 - s * DIV_BITS_PER_STAGE - j;
        sh = {20'd0, cur.dmag} << k;
        if ({4'd0, cur.rem} >= sh) begin
          cur.rem = 32'({4'd0, cur.rem} - sh);
          cur.q   = cur.q | (DIV_QBITS'(1) << k);
        end
      end
      st_nxt[s+1] = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (en) st_r <= st_nxt;
  end

  // saturation on the final stage
  always_comb begin
    div_st_t f;
    f = st_r[DIV_STAGES];
    ovf  = 1'b0;
    quot = 16'(f.q);
    if (f.zero) begin
      ovf  = 1'b1;
      quot = f.nneg ? -16'sd32768 : 16'sd32767;
    end else if (!f.neg) begin
      if (f.big || f.q > DIV_QBITS'(32767)) begin
        ovf  = 1'b1;
        quot = 16'sd32767;
      end
    end else begin
      if (f.big || f.q > DIV_QBITS'(32768)) begin
        ovf  = 1'b1;
        quot = -16'sd32768;
      end else begin
        quot = 16'(-f.q);
      end
    end
  end

endmodule
`default_nettype wire

>>> design/vertex_perspective_transform.sv
// Vertex transform and perspective projection, fully pipelined.
// Input channel (in_valid / in_stall / in_data): one vertex per beat,
// three signed 16-bit object-space coordinates.
// Result channel (out_valid / out_stall / out_data): one beat per vertex,
// screen x/y, 16-bit depth and a divide overflow flag, in input order.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always
// ready; write only while the pipe is empty.
// Pipeline: 2 transform stages, 1 divide prep stage, 5 divide stages of
// 4 quotient bits, then the output reg.
// Throughput: one vertex per cycle while out_stall holds no result, set by
// the restoring divider being unrolled across its 5 stages.
// Reset (rst_n low, synchronous): valid bits cleared, coefficients and
// offsets zero, centres 128.
// Stall: while out_stall holds a pending result the whole pipe freezes and
// in_stall goes high; nothing is dropped or repeated.
`default_nettype none
module vertex_perspective_transform
  import vpt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire vpt_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output vpt_out_t         out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [47:0] cfg_data
);

  logic [47:0]        row_x_r, row_y_r, row_z_r;
  logic signed [15:0] offset_x_r, offset_y_r, offset_z_r;
  logic [14:0]        centre_x_r, centre_y_r;

  logic                  adv;
  logic [PIPE_DEPTH-1:0] vld_r;
  logic                  out_valid_r;
  vpt_out_t              out_data_r;

  logic signed [31:0] view_x, view_y;
  logic signed [15:0] depth;
  logic signed [15:0] depth_line_r [DIV_STAGES+1];
  logic signed [15:0] qx, qy;
  logic               ovf_x, ovf_y;

  assign cfg_ready = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_x_r    <= '0;
      row_y_r    <= '0;
      row_z_r    <= '0;
      offset_x_r <= '0;
      offset_y_r <= '0;
      offset_z_r <= '0;
      centre_x_r <= 15'(CENTRE_RESET);
      centre_y_r <= 15'(CENTRE_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROW_X:    row_x_r    <= cfg_data;
        REG_ROW_Y:    row_y_r    <= cfg_data;
        REG_ROW_Z:    row_z_r    <= cfg_data;
        REG_OFFSET_X: offset_x_r <= cfg_data[15:0];
        REG_OFFSET_Y: offset_y_r <= cfg_data[15:0];
        REG_OFFSET_Z: offset_z_r <= cfg_data[15:0];
        REG_CENTRE_X: centre_x_r <= cfg_data[14:0];
        REG_CENTRE_Y: centre_y_r <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // whole pipe advances unless a finished beat is held
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[PIPE_DEPTH-2:0], in_valid};
      out_valid_r <= vld_r[PIPE_DEPTH-1];
    end
  end

  vpt_transform u_xform (
    .clk      (clk),
    .en       (adv),
    .vtx      (in_data),
    .row_x    (row_x_r),
    .row_y    (row_y_r),
    .row_z    (row_z_r),
    .offset_x (offset_x_r),
    .offset_y (offset_y_r),
    .offset_z (offset_z_r),
    .view_x   (view_x),
    .view_y   (view_y),
    .depth    (depth)
  );

  vpt_divider u_div_x (
    .clk  (clk),
    .en   (adv),
    .num  (view_x),
    .den  (depth),
    .quot (qx),
    .ovf  (ovf_x)
  );

  vpt_divider u_div_y (
    .clk  (clk),
    .en   (adv),
    .num  (view_y),
    .den  (depth),
    .quot (qy),
    .ovf  (ovf_y)
  );

  // depth rides alongside the divider stages
  always_ff @(posedge clk) begin
    if (adv) begin
      depth_line_r[0] <= depth;
      for (int i = 1; i <= DIV_STAGES; i++)
        depth_line_r[i] <= depth_line_r[i-1];
    end
  end

  // output register: add screen centre, wrap to 16 bits
  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.screen_x        <= qx + $signed({1'b0, centre_x_r});
      out_data_r.screen_y        <= qy + $signed({1'b0, centre_y_r});
      out_data_r.depth           <= depth_line_r[DIV_STAGES];
      out_data_r.divide_overflow <= ovf_x | ovf_y;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(vld_r))
    else $error("pipe valid bits moved while stalled");
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_r[0])
    else $error("accepted beat lost at pipe entry");
  a_zero_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.depth == 16'sd0)) |-> out_data_r.divide_overflow)
    else $error("zero depth without overflow flag");
`endif

endmodule
`default_nettype wire

>>> bench/vertex_perspective_transform_checker.sv
`timescale 1ns / 100ps
module vertex_perspective_transform_checker
  import vpt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire vpt_in_t     in_data,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire vpt_out_t    out_data,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [47:0] cfg_data,
  output int               fail_count,
  output int               pending,
  output int               beats_out
);

  logic [47:0] coef_row [3];
  logic [15:0] ofs_x, ofs_y, ofs_z;
  logic [14:0] ctr_x, ctr_y;
  vpt_out_t    screen_q [$];

  assign pending = screen_q.size();

  // paired-product row: (a+y)(b+x) + c*z - x*y, pre-sums wrapped to 16 bits
  function automatic logic [31:0] row_acc(input logic [47:0] row, input vpt_in_t v,
                                          output logic [31:0] ab);
    logic signed [15:0] a, b, c, t0, t1;
    logic signed [31:0] p0, p1, p2;
    a = row[15:0]; b = row[31:16]; c = row[47:32];
    t0 = a + v.vertex_y;
    t1 = b + v.vertex_x;
    p0 = t0 * t1; p1 = c * v.vertex_z; p2 = v.vertex_x * v.vertex_y;
    ab = 32'(signed'(a) * signed'(b));
    return p0 + p1 - p2;
  endfunction

  function automatic logic signed [15:0] sat_quot(input logic signed [31:0] num,
                                                  input logic signed [15:0] den,
                                                  inout logic ovf);
    longint q;
    if (den == 0) begin
      ovf = 1'b1;
      return (num >= 0) ? 16'sh7fff : 16'sh8000;
    end
    q = longint'(num) / longint'(den);
    if (q > 32767) begin ovf = 1'b1; return 16'sh7fff; end
    if (q < -32768) begin ovf = 1'b1; return 16'sh8000; end
    return q[15:0];
  endfunction

  function automatic vpt_out_t project(input vpt_in_t v);
    logic [31:0] sx, sy, sz, cx, cy, cz, vx, vy, dz;
    logic signed [15:0] qx, qy;
    logic ovf;
    vpt_out_t r;
    sx = row_acc(coef_row[0], v, cx);
    sy = row_acc(coef_row[1], v, cy);
    sz = row_acc(coef_row[2], v, cz);
    vx = ($signed(sx) >>> 4) + $signed({{8{ofs_x[15]}}, ofs_x, 8'h00}) - ($signed(cx) >>> 4);
    vy = ($signed(sy) >>> 4) + $signed({{8{ofs_y[15]}}, ofs_y, 8'h00}) - ($signed(cy) >>> 4);
    dz = ($signed(sz) >>> 12) + $signed({{16{ofs_z[15]}}, ofs_z}) - ($signed(cz) >>> 12);
    ovf = 1'b0;
    qx = sat_quot(vx, dz[15:0], ovf);
    qy = sat_quot(vy, dz[15:0], ovf);
    r.screen_x = qx + {1'b0, ctr_x};
    r.screen_y = qy + {1'b0, ctr_y};
    r.depth = dz[15:0];
    r.divide_overflow = ovf;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    vpt_out_t want;
    if (!rst_n) begin
      coef_row[0] <= '0; coef_row[1] <= '0; coef_row[2] <= '0;
      ofs_x <= '0; ofs_y <= '0; ofs_z <= '0;
      ctr_x <= 15'(CENTRE_RESET); ctr_y <= 15'(CENTRE_RESET);
      fail_count = 0;
      beats_out <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        beats_out <= beats_out + 1;
        if (screen_q.size() == 0) begin
          report_mismatch("unexpected result beat", 1, 0);
        end else begin
          want = screen_q.pop_front();
          if (out_data.screen_x !== want.screen_x)
            report_mismatch("screen_x", out_data.screen_x, want.screen_x);
          if (out_data.screen_y !== want.screen_y)
            report_mismatch("screen_y", out_data.screen_y, want.screen_y);
          if (out_data.depth !== want.depth)
            report_mismatch("depth", out_data.depth, want.depth);
          if (out_data.divide_overflow !== want.divide_overflow)
            report_mismatch("divide_overflow", out_data.divide_overflow,
                            want.divide_overflow);
        end
      end
      if (in_valid && !in_stall) screen_q.push_back(project(in_data));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROW_X:    coef_row[0] <= cfg_data;
          REG_ROW_Y:    coef_row[1] <= cfg_data;
          REG_ROW_Z:    coef_row[2] <= cfg_data;
          REG_OFFSET_X: ofs_x <= cfg_data[15:0];
          REG_OFFSET_Y: ofs_y <= cfg_data[15:0];
          REG_OFFSET_Z: ofs_z <= cfg_data[15:0];
          REG_CENTRE_X: ctr_x <= cfg_data[14:0];
          REG_CENTRE_Y: ctr_y <= cfg_data[14:0];
          default: ;
        endcase
      end
    end
  end

endmodule

>>> bench/vertex_perspective_transform_test.sv
`timescale 1ns / 100ps
module vertex_perspective_transform_test;
  import vpt_pkg::*;

  localparam int IDLE_LIMIT = 20000;  // cycles with no beat on any channel
  localparam int DRAIN_GAP  = 2 * PIPE_DEPTH + 4;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  vpt_in_t     in_data;
  logic        out_valid;
  logic        out_stall;
  vpt_out_t    out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [47:0] cfg_data;

  int fail_count, pending, beats_out;
  int send_idle_pct, recv_idle_pct;  // percent of cycles each side idles
  int hold_cycles;                   // long receiver hold-off, run in its own process
  int quiet_cycles;
  int cfg_sets;

  vertex_perspective_transform i_dut (.*);

  vertex_perspective_transform_checker i_check (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pending, .beats_out
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver: random stall, or a counted hold-off when one is requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // watchdog: any accepted beat resets the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
        $display("vertex_perspective_transform test failed");
        $finish;
      end
    end
  end

  // one vertex beat; valid stays up across back-to-back beats
  task automatic send_vertex(input vpt_in_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  // drops cfg_valid again before returning after each write
  task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_coef(input int mode);
    case (mode)
      0: return 16'h1000;            // unity in 4.12
      1: return 16'h7fff;
      2: return 16'h8000;
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // mode 0: all extremes/zeros; otherwise mostly well-behaved random matrices
  task automatic load_setting(input int mode);
    logic [47:0] row;
    for (int r = 0; r < 3; r++) begin
      row = {pick_coef(mode == 0 ? 2 : $urandom_range(5)),
             pick_coef(mode == 0 ? 1 : $urandom_range(5)),
             pick_coef(mode == 0 ? 2 : $urandom_range(5))};
      write_reg(3'(r), row);
    end
    write_reg(REG_OFFSET_X, mode == 0 ? 48'h7fff : 48'($urandom));
    write_reg(REG_OFFSET_Y, mode == 0 ? 48'h8000 : 48'($urandom));
    write_reg(REG_OFFSET_Z, mode == 0 ? 48'h8000 : 48'($urandom_range(4000, 100)));
    write_reg(REG_CENTRE_X, mode == 0 ? 48'h7fff : 48'($urandom_range(32767)));
    write_reg(REG_CENTRE_Y, mode == 0 ? 48'h0000 : 48'($urandom_range(32767)));
    cfg_sets++;
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'($urandom);
      default: return 16'($signed(16'($urandom_range(2000))) - 16'sd1000);
    endcase
  endfunction

  task automatic random_vertices(input int n);
    vpt_in_t v;
    repeat (n) begin
      v.vertex_x = rand_coord();
      v.vertex_y = rand_coord();
      v.vertex_z = rand_coord();
      send_vertex(v);
    end
  endtask

  initial begin
    vpt_in_t v;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles <= 0;
    cfg_sets = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: zero matrix gives zero depth, so every beat saturates
    v = '{16'sh7fff, 16'sh8000, 16'sh0000};
    send_vertex(v);
    v = '{16'sh8000, 16'sh7fff, 16'sh7fff};
    send_vertex(v);
    drain_pipe();

    // identity-ish rows with a depth offset: ordinary division
    write_reg(REG_ROW_X, {16'h0000, 16'h0000, 16'h1000});
    write_reg(REG_ROW_Y, {16'h0000, 16'h1000, 16'h0000});
    write_reg(REG_ROW_Z, {16'h1000, 16'h0000, 16'h0000});
    write_reg(REG_OFFSET_Z, 48'd256);
    for (int i = 0; i < 16; i++) begin
      v = '{16'(1 << i), 16'(-(1 << i)), 16'(i * 37)};
      send_vertex(v);
    end
    v = '{16'sh0000, 16'sh0000, -16'sd256};  // zero depth, zero dividend
    send_vertex(v);
    v = '{16'sh7fff, 16'sh7fff, -16'sd255};  // depth 1: quotient overflow
    send_vertex(v);
    v = '{16'sh8000, 16'sh8000, -16'sd257};  // negative depth
    send_vertex(v);
    drain_pipe();

    // extreme setting
    load_setting(0);
    random_vertices(20);
    drain_pipe();

    // random phases across three idling regimes
    for (int ph = 0; ph < 15; ph++) begin
      send_idle_pct = (ph < 5) ? 6 : (ph < 10) ? 59 : 0;
      recv_idle_pct = (ph < 5) ? 59 : (ph < 10) ? 6 : 0;
      load_setting(1);
      if (ph == 12) hold_cycles <= 200;  // block fills and stalls its input
      random_vertices(105);
      drain_pipe();  // sender pauses until everything has come back
    end

    $display("covered %0d configuration sets, %0d result beats checked", cfg_sets, beats_out);
    $display("with random idling on both sides and a long receiver hold-off");
    if (fail_count == 0) begin
      $display("vertex_perspective_transform test passed");
    end else begin
      $display("vertex_perspective_transform test failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/vpt_pkg.sv
design/vpt_transform.sv
design/vpt_divider.sv
design/vertex_perspective_transform.sv
bench/vertex_perspective_transform_checker.sv
bench/vertex_perspective_transform_test.sv
